### rtl/core/ped_pkg.sv
package ped_pkg;

  // Default sizes of the point store.
  localparam int MAX_POINTS_DEF   = 256;
  localparam int MAX_FEATURES_DEF = 16;
  localparam int VALUE_BITS_DEF   = 16;

  // Field widths of the input and result words.
  localparam int PT_W   = 8;
  localparam int FIDX_W = 4;
  localparam int FVAL_W = 16;
  localparam int DIST_W = 18;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int IN_PAD     = IN_DATA_W - 2 * PT_W - FIDX_W - FVAL_W;
  localparam int OUT_PAD    = OUT_DATA_W - DIST_W - 2 * PT_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;
  localparam int NP_W       = 9;
  localparam int NF_W       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = CFG_IDX_W'(1);

  localparam logic [NP_W-1:0] NUM_POINTS_RST   = NP_W'(256);
  localparam logic [NF_W-1:0] NUM_FEATURES_RST = NF_W'(16);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

endpackage

### rtl/core/ped_isqrt.sv
module ped_isqrt import ped_pkg::*; #(
  parameter int SUM_W = 37
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SUM_W-1:0]           radicand_i,
  output logic                       done_o,
  output logic [(SUM_W+1)/2-1:0]     root_o
);

  localparam int RW = (SUM_W + 1) / 2;
  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            done_q;

  logic [RW+2:0]   cur;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   cur_sub;
  logic            fits;

  // One root bit per cycle: bring down two radicand bits, try root*4+1.
  assign cur     = {rem_q, rad_q[2*RW-1 -: 2]};
  assign trial   = (RW+3)'({root_q, 2'b01});
  assign fits    = cur >= trial;
  assign cur_sub = cur - trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= (2*RW)'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[2*RW-3:0], 2'b00};
      rem_q  <= fits ? cur_sub[RW:0] : cur[RW:0];
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1)) && !start_i;
      if (start_i) begin
        cnt_q <= CW'(RW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/core/pairwise_euclidean_distance_core.sv
// Pairwise Euclidean distance over a store of points with signed Q8.8 features. A load word
// (tuser 0) writes one feature of one point and the block stays ready. A query word (tuser 1)
// names two points and returns one result word: the floor square root of the summed squared
// differences over the configured feature count, in unsigned Q.8, with status 1 and distance
// 0 if either point is at or beyond the configured point count. A query keeps the input side
// busy through the read, drain, root and done states, until its result is loaded into the
// output register; an out-of-range query or a zero feature count goes straight to the done
// state. The single read port of the store gives one of the two values per feature each
// cycle, and the square root unit settles one bit a cycle, the root being 19 bits wide at the
// default sizes. A result waits in an output register, so the next word is taken while it is
// still unread. Store entries are undefined after reset until loaded.
module pairwise_euclidean_distance_core import ped_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // first_point, second_point, feature_index, feature_value, zero padding
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // distance, pair_first, pair_second, zero padding
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic                  m_axis_tuser
);

  localparam int EW     = (VALUE_BITS < FVAL_W) ? VALUE_BITS : FVAL_W;
  localparam int DEPTH  = MAX_POINTS * MAX_FEATURES;
  localparam int AW     = $clog2(DEPTH);
  localparam int FC_W   = $clog2(MAX_FEATURES + 1);
  localparam int FI_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int SUM_W  = 2 * EW + FC_W;
  localparam int ROOT_W = (SUM_W + 1) / 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROOT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [NP_W-1:0] num_points_q;
  logic [NF_W-1:0] num_features_q;

  // Input word fields.
  op_e               in_op;
  logic [PT_W-1:0]   in_a;
  logic [PT_W-1:0]   in_b;
  logic [FIDX_W-1:0] in_f;
  logic [FVAL_W-1:0] in_v;
  logic              in_acc;
  logic              query_acc;

  logic              a_oor;
  logic              b_oor;
  logic [FC_W-1:0]   lim_f_in;

  logic [PT_W-1:0]   a_q;
  logic [PT_W-1:0]   b_q;
  logic [FC_W-1:0]   lim_f_q;
  logic [FC_W:0]     cnt_q, cnt_d;

  // Store.
  logic [VALUE_BITS-1:0] store_q [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  ld_ok;
  logic                  we;
  logic                  re;
  logic signed [EW-1:0]  ld_val;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [PT_W-1:0]       rd_pt;
  logic [FI_W-1:0]       rd_k;
  logic                  last_beat;

  // Difference, square and accumulate.
  logic                   rv_q;
  logic                   rsel_q;
  logic                   dv_q;
  logic                   sv_q;
  logic signed [EW-1:0]   va_q;
  logic signed [EW-1:0]   rd_lo;
  logic signed [EW:0]     diff_q;
  logic signed [2*EW+1:0] sq_full;
  logic [2*EW-1:0]        sq_q;
  logic [SUM_W-1:0]       sum_q;
  logic                   drained;

  logic                   sq_start;
  logic                   sq_done;
  logic [ROOT_W-1:0]      root;

  logic [DIST_W-1:0]      res_dist_q, res_dist_d;
  logic                   res_st_q, res_st_d;

  logic                   out_valid_q;
  logic [DIST_W-1:0]      out_dist_q;
  logic [PT_W-1:0]        out_a_q;
  logic [PT_W-1:0]        out_b_q;
  logic                   out_st_q;
  logic                   out_load;

  assign in_op     = op_e'(s_axis_tuser);
  assign in_a      = s_axis_tdata[PT_W-1:0];
  assign in_b      = s_axis_tdata[2*PT_W-1:PT_W];
  assign in_f      = s_axis_tdata[2*PT_W+FIDX_W-1:2*PT_W];
  assign in_v      = s_axis_tdata[2*PT_W+FIDX_W+FVAL_W-1:2*PT_W+FIDX_W];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign query_acc = in_acc && (in_op == OP_QUERY);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= NUM_POINTS_RST;
      num_features_q <= NUM_FEATURES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_POINTS:   num_points_q   <= cfg_data_i[NP_W-1:0];
        CFG_NUM_FEATURES: num_features_q <= cfg_data_i[NF_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_oor = (32'(in_a) >= 32'(num_points_q)) || (32'(in_a) >= MAX_POINTS);
  assign b_oor = (32'(in_b) >= 32'(num_points_q)) || (32'(in_b) >= MAX_POINTS);
  assign lim_f_in = (32'(num_features_q) > MAX_FEATURES) ? FC_W'(MAX_FEATURES)
                                                         : FC_W'(num_features_q);

  // Loads keep only the low bits that the stored width allows, sign extended.
  assign ld_ok   = (32'(in_a) < MAX_POINTS) && (32'(in_f) < MAX_FEATURES);
  assign we      = in_acc && (in_op == OP_LOAD) && ld_ok;
  assign ld_val  = in_v[EW-1:0];
  assign wr_addr = AW'(32'(in_a) * MAX_FEATURES + 32'(in_f));

  // Even beats read the first point, odd beats the second, for the same feature.
  assign rd_pt     = cnt_q[0] ? b_q : a_q;
  assign rd_k      = FI_W'(cnt_q[FC_W:1]);
  assign rd_addr   = AW'(32'(rd_pt) * MAX_FEATURES + 32'(rd_k));
  assign re        = (state_q == S_READ);
  assign last_beat = cnt_q[0] && (cnt_q[FC_W:1] == FC_W'(lim_f_q - FC_W'(1)));

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wr_addr] <= VALUE_BITS'(ld_val);
    end
    if (re) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  assign rd_lo   = rdata_q[EW-1:0];
  assign sq_full = diff_q * diff_q;
  assign drained = !rv_q && !dv_q && !sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      dv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      rv_q <= re;
      dv_q <= rv_q && rsel_q;
      sv_q <= dv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsel_q <= cnt_q[0];
    if (rv_q && !rsel_q) begin
      va_q <= rd_lo;
    end
    if (rv_q && rsel_q) begin
      diff_q <= (EW+1)'(va_q) - (EW+1)'(rd_lo);
    end
    if (dv_q) begin
      sq_q <= sq_full[2*EW-1:0];
    end
    if (query_acc) begin
      sum_q <= '0;
    end else if (sv_q) begin
      sum_q <= sum_q + SUM_W'(sq_q);
    end
    if (query_acc) begin
      a_q     <= in_a;
      b_q     <= in_b;
      lim_f_q <= lim_f_in;
    end
  end

  assign sq_start = (state_q == S_DRAIN) && drained;

  ped_isqrt #(
    .SUM_W (SUM_W)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sum_q),
    .done_o     (sq_done),
    .root_o     (root)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    res_dist_d = res_dist_q;
    res_st_d   = res_st_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (query_acc) begin
          if (a_oor || b_oor) begin
            res_dist_d = '0;
            res_st_d   = 1'b1;
            state_d    = S_DONE;
          end else if (lim_f_in == '0) begin
            res_dist_d = '0;
            res_st_d   = 1'b0;
            state_d    = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cnt_d = cnt_q + (FC_W+1)'(1);
        if (last_beat) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          res_dist_d = (32'(root) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(root);
          res_st_d   = 1'b0;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_dist_q <= res_dist_d;
    res_st_q   <= res_st_d;
    if (out_load) begin
      out_dist_q <= res_dist_q;
      out_a_q    <= a_q;
      out_b_q    <= b_q;
      out_st_q   <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_b_q, out_a_q, out_dist_q};
  assign m_axis_tuser  = out_st_q;

endmodule

### rtl/core/ped_checker.sv
module ped_checker import ped_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // A query word keeps the input side busy for at least the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY)) |=> !s_axis_tready)
    else $error("input still ready after a query word");

  // A load word is taken and leaves the block ready.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD)) |=> s_axis_tready)
    else $error("input not ready after a load word");

  // An out-of-range answer carries a zero distance.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[DIST_W-1:0] == '0))
    else $error("out-of-range result with non-zero distance");

  // A new result only comes out of a query in progress.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while no query was in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind pairwise_euclidean_distance_core ped_checker u_ped_checker (.*);
